// ===== src/lrr_pkg.sv =====
// Shared types and constants for the LCG random unit with range output.
// Used by lrr_ctrl, lrr_datapath, lcg_random_with_range_unit and lrr_checker.
`default_nettype none

package lrr_pkg;

  // Generator constants
  localparam logic [31:0] LCG_MUL = 32'd8453629;
  localparam logic [31:0] LCG_ADD = 32'd2395493;

  // Fraction output width (numerator over 2^FRACTION_BITS)
  localparam int unsigned FRACTION_BITS = 14;
  localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRACTION_BITS) - 64'd1);

  // Remainder unit: one quotient bit per cycle over the 32-bit word
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // Request selector codes
  localparam logic [1:0] REQ_RAW     = 2'd0;
  localparam logic [1:0] REQ_FRAC    = 2'd1;
  localparam logic [1:0] REQ_RANGE   = 2'd2;
  localparam logic [1:0] REQ_RAW_ALT = 2'd3;

  // Configuration space
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_SEED = 1'b0;  // register index, taken from paddr[2]

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  range_low;
    logic signed [31:0]  range_high;
  } req_t;

  typedef struct packed {
    logic signed [32:0]  value;
    logic                bad_range;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the request
    logic decode;    // register the span
    logic step;      // advance the generator, arm the remainder unit
    logic div_step;  // one remainder iteration
    logic out_load;  // result goes to the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_adv;  // range request that leaves the state alone
    logic need_div;  // range request with a span below 2^32
    logic div_last;  // final remainder iteration
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_STEP   = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== src/lcg_random_with_range_unit.sv =====
// LCG random unit with raw, fraction and signed-range requests: top level.
// Instantiates lrr_ctrl and lrr_datapath; uses lrr_pkg.
//
// Each request gives one result. Raw and fraction requests and full-span
// ranges pass through decode, generator step and done; single-value and
// reversed ranges go from decode straight to done; a range request with a span
// below 2^32 adds the remainder iterations after the step, where the restoring
// remainder unit in lrr_datapath retires one bit per cycle over the 32-bit
// generator word. The sequencer returns to idle on the same edge that moves
// the result into the output register, and only takes a new request in idle.
// While a result waits on out_stall_i, one further request is taken and worked
// on; the one after it is held off until the output register frees up.
// Writing the seed register (byte address 0) loads the generator state at
// once; reads return the last value written.
`default_nettype none

module lcg_random_with_range_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire lrr_pkg::req_t                 in_req_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output lrr_pkg::rsp_t                      out_rsp_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lrr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  lrr_pkg::ctrl_cmd_t  cmd;
  lrr_pkg::dp_status_t status;
  lrr_pkg::rsp_t       rsp;

  logic        seed_wr;
  logic [31:0] seed_cfg_q;
  logic        out_valid_q;
  logic        out_free;
  lrr_pkg::rsp_t out_rsp_q;

  // Configuration: single seed register, zero-wait access
  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[2] == lrr_pkg::REG_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_cfg_q <= '0;
    end else if (seed_wr) begin
      seed_cfg_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == lrr_pkg::REG_SEED) ? seed_cfg_q : '0;

  // Output register is free when empty or when its result leaves this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  lrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lrr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .seed_load_i (seed_wr),
    .seed_data_i (pwdata),
    .status_o    (status),
    .rsp_o       (rsp)
  );

  // Result register: load a finished result, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ===== src/lrr_ctrl.sv =====
// Sequencer for the LCG random unit: walks one request through decode,
// generator step, remainder iterations and result hand-off. Uses lrr_pkg.
`default_nettype none

module lrr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               out_free_i,
  input  wire lrr_pkg::dp_status_t status_i,
  output lrr_pkg::ctrl_cmd_t      cmd_o
);

  lrr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lrr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lrr_pkg::S_DECODE;
        end
      end
      lrr_pkg::S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = status_i.skip_adv ? lrr_pkg::S_DONE : lrr_pkg::S_STEP;
      end
      lrr_pkg::S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.need_div ? lrr_pkg::S_DIV : lrr_pkg::S_DONE;
      end
      lrr_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = lrr_pkg::S_DONE;
        end
      end
      lrr_pkg::S_DONE: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = lrr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lrr_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != lrr_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== src/lrr_datapath.sv =====
// Datapath of the LCG random unit: generator state, request latch,
// restoring remainder unit and result select. Uses lrr_pkg.
`default_nettype none

module lrr_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lrr_pkg::ctrl_cmd_t  cmd_i,
  input  wire lrr_pkg::req_t       req_i,
  input  wire logic                seed_load_i,
  input  wire logic [31:0]         seed_data_i,
  output lrr_pkg::dp_status_t      status_o,
  output lrr_pkg::rsp_t            rsp_o
);

  logic [31:0]              seed_q, seed_d;
  lrr_pkg::req_t            req_q;
  logic [32:0]              span_q;
  logic [31:0]              word_q;   // dividend, shifted out MSB first
  logic [31:0]              rem_q;
  logic [lrr_pkg::CNT_W-1:0] cnt_q;

  logic        is_range, is_bad, is_eq, is_full;
  logic [32:0] diff, trial;
  logic [31:0] rem_d;
  logic [32:0] range_sum;

  // Generator update, low 32 bits only
  assign seed_d = seed_q * lrr_pkg::LCG_MUL + lrr_pkg::LCG_ADD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_load_i) begin
      seed_q <= seed_data_i;
    end else if (cmd_i.step) begin
      seed_q <= seed_d;
    end
  end

  assign is_range = (req_q.req_type == lrr_pkg::REQ_RANGE);
  assign is_bad   = (req_q.range_high < req_q.range_low);
  assign is_eq    = (req_q.range_high == req_q.range_low);
  assign is_full  = (req_q.range_low == 32'sh8000_0000) &&
                    (req_q.range_high == 32'sh7FFF_FFFF);

  assign diff = {req_q.range_high[31], req_q.range_high} -
                {req_q.range_low[31], req_q.range_low};

  // Restoring step: remainder stays below span, so the trial fits 33 bits
  assign trial = {rem_q, word_q[31]};
  assign rem_d = (trial >= span_q) ? 32'(trial - span_q) : trial[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.decode) begin
      span_q <= diff + 33'd1;
    end
    if (cmd_i.step) begin
      word_q <= seed_d;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      word_q <= {word_q[30:0], 1'b0};
      rem_q  <= rem_d;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  assign status_o.skip_adv = is_range && (is_bad || is_eq);
  assign status_o.need_div = is_range && !is_full;
  assign status_o.div_last = (cnt_q == lrr_pkg::CNT_LAST);

  assign range_sum = {req_q.range_low[31], req_q.range_low} + {1'b0, rem_q};

  always_comb begin
    rsp_o.bad_range = 1'b0;
    unique case (req_q.req_type)
      lrr_pkg::REQ_FRAC: begin
        rsp_o.value = {1'b0, seed_q & lrr_pkg::FRAC_MASK};
      end
      lrr_pkg::REQ_RANGE: begin
        if (is_bad) begin
          rsp_o.value     = '0;
          rsp_o.bad_range = 1'b1;
        end else if (is_eq) begin
          rsp_o.value = {req_q.range_low[31], req_q.range_low};
        end else if (is_full) begin
          rsp_o.value = {1'b0, seed_q};
        end else begin
          rsp_o.value = range_sum;
        end
      end
      lrr_pkg::REQ_RAW, lrr_pkg::REQ_RAW_ALT: begin
        rsp_o.value = {1'b0, seed_q};
      end
      default: begin
        rsp_o.value = {1'b0, seed_q};
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/lrr_checker.sv =====
// Port-level checks for lcg_random_with_range_unit, bound to the top level.
// Uses lrr_pkg types.
`default_nettype none

module lrr_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire lrr_pkg::rsp_t out_rsp_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("result changed while stalled");

  // A reversed range reports zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.bad_range |-> out_rsp_o.value == '0)
    else $error("bad range with nonzero value");

  // One request at a time: the input side closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

endmodule

bind lcg_random_with_range_unit lrr_checker u_lrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
